### rtl/elsa_pkg.sv
// Package for the edge load scatter-accumulate block.
// Holds shared constants, the command codes and the state encoding.
// No dependencies.
package elsa_pkg;

  localparam int unsigned NodesDef    = 1024;
  localparam int unsigned MaxBlockDef = 4;
  localparam int unsigned AccW        = 48;
  localparam int unsigned CoordW      = 24;
  localparam int unsigned ValW        = 32;
  localparam int unsigned NodeW       = 10;
  localparam int unsigned RaddrW      = 12;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SCALE     = 2'd0,
    REG_NODE_DOFS = 2'd1,
    REG_COMPONENT = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_MUL,
    ST_MUL2,
    ST_ADDR,
    ST_RD0,
    ST_WR0,
    ST_RD1,
    ST_WR1,
    ST_RREAD,
    ST_RDATA,
    ST_OUT
  } state_e;

endpackage

### rtl/edge_load_scatter_accumulate.sv
// Top level of the edge load scatter-accumulate block.
// Depends on elsa_pkg. Holds the accumulator memory and its sequencer.
//
// Usage: items enter on s_axis (tdata carries the edge or read fields, tuser
// the command, tlast the last-edge mark). One result per item leaves on m_axis
// with the same tlast. The user writes the configuration registers (scale,
// dofs per node, component) through cfg_we_i/cfg_idx_i/cfg_data_i only while idle.
// The block does not enforce this. After reset a clearing pass writes zero to
// every accumulator entry, one entry a cycle (DEPTH = NODES*MAX_BLOCK entries,
// 4096 by default); no item is accepted during it.
// After acceptance, an add item runs through its states in order: ST_SQ squares
// the deltas, ST_SQRT resolves one square root bit a cycle (25 bits in all),
// ST_MUL and ST_MUL2 multiply, ST_ADDR forms the addresses, two
// read-modify-write passes (ST_RD0/ST_WR0, ST_RD1/ST_WR1) on the single-port
// memory follow, and ST_OUT loads the output register. A read item passes
// through ST_RREAD and ST_RDATA to ST_OUT, and an add with a component not
// below the dofs per node goes straight to ST_OUT. The next item can be
// accepted in the cycle after the result is loaded. One item is in work at a
// time; a stalled receiver holds the finished result in the output register,
// and the following item waits in its last state until that register frees.
module edge_load_scatter_accumulate #(
  parameter int unsigned NODES     = elsa_pkg::NodesDef,
  parameter int unsigned MAX_BLOCK = elsa_pkg::MaxBlockDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // first_node[9:0], second_node[19:10], x_first[43:20], y_first[67:44],
  // x_second[91:68], y_second[115:92], element_value[147:116],
  // read_address[159:148], zero fill [167:160]
  input  logic [167:0]  s_axis_tdata,
  // cmd[0]
  input  logic          s_axis_tuser,
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // contribution[47:0], read_data[95:48], error[96], zero fill [103:97]
  output logic [103:0]  m_axis_tdata,
  output logic          m_axis_tlast
);

  localparam int unsigned Depth = NODES * MAX_BLOCK;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned AccW  = elsa_pkg::AccW;

  // Memory and clearing pass.
  logic signed [AccW-1:0] mem_q [Depth];
  logic signed [AccW-1:0] rdata_q;
  logic [AddrW:0]         clr_q, clr_d;
  logic                   clearing;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_addr;
  logic signed [AccW-1:0] mem_wdata;

  // Configuration.
  logic signed [31:0] scale_q;
  logic [2:0]         bsize_q;
  logic [1:0]         comp_q;

  // Sequencer state.
  elsa_pkg::state_e   state_q, state_d;
  logic [9:0]         n0_q, n1_q;
  logic [elsa_pkg::RaddrW-1:0] raddr_q;
  logic               last_q;
  logic signed [31:0] ev_q;
  logic signed [24:0] dx_q, dy_q;
  logic [49:0]        rem_q, rem_d;      // sqrt radicand / remainder
  logic [25:0]        root_q, root_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [63:0]        prod_q;
  logic               neg_q;
  logic [47:0]        v_q;
  logic [73:0]        m_q;
  logic signed [AccW-1:0] contrib_q;
  logic [AddrW+16:0]  a0_q, a1_q;
  logic               a0_ok, a1_ok;

  // Output register.
  logic               ovalid_q;
  logic signed [AccW-1:0] ocontrib_q, ordata_q;
  logic               oerr_q, olast_q;
  logic               err_pend_q;
  logic signed [AccW-1:0] rd_hold_q;

  assign clearing      = (clr_q < (AddrW+1)'(Depth));
  assign s_axis_tready = (state_q == elsa_pkg::ST_IDLE) && !clearing;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, oerr_q, ordata_q, ocontrib_q};
  assign m_axis_tlast  = olast_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 32'sd65536;
      bsize_q <= 3'd1;
      comp_q  <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        elsa_pkg::REG_SCALE:     scale_q <= cfg_data_i;
        elsa_pkg::REG_NODE_DOFS: bsize_q <= cfg_data_i[2:0];
        elsa_pkg::REG_COMPONENT: comp_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Saturating sum of an entry and the contribution.
  function automatic logic signed [AccW-1:0] sat_add(logic signed [AccW-1:0] a,
                                                     logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) return s[AccW] ? elsa_pkg::AccMin : elsa_pkg::AccMax;
    return s[AccW-1:0];
  endfunction

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    if (clearing) begin
      mem_we   = 1'b1;
      mem_addr = clr_q[AddrW-1:0];
    end else begin
      case (state_q)
        elsa_pkg::ST_RD0: mem_addr = a0_q[AddrW-1:0];
        elsa_pkg::ST_WR0: begin
          mem_addr  = a0_q[AddrW-1:0];
          mem_we    = a0_ok;
          mem_wdata = sat_add(rdata_q, contrib_q);
        end
        elsa_pkg::ST_RD1: mem_addr = a1_q[AddrW-1:0];
        elsa_pkg::ST_WR1: begin
          mem_addr  = a1_q[AddrW-1:0];
          mem_we    = a1_ok;
          mem_wdata = sat_add(rdata_q, contrib_q);
        end
        elsa_pkg::ST_RREAD: mem_addr = AddrW'(raddr_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else         clr_q <= clr_d;
  end
  assign clr_d = clearing ? clr_q + 1'b1 : clr_q;

  // Next state and sqrt stepping.
  logic [25:0] sq_step;
  logic [49:0] rem_hi;
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    sq_step = '0;
    rem_hi  = '0;
    unique case (state_q)
      elsa_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser == elsa_pkg::CMD_READ) state_d = elsa_pkg::ST_RREAD;
          else if ({1'b0, comp_q} >= bsize_q)    state_d = elsa_pkg::ST_OUT;
          else                                    state_d = elsa_pkg::ST_SQ;
        end
      end
      elsa_pkg::ST_SQ: begin
        rem_d   = 50'(dx_q * dx_q) + 50'(dy_q * dy_q);
        root_d  = '0;
        cnt_d   = 5'd24;
        state_d = elsa_pkg::ST_SQRT;
      end
      elsa_pkg::ST_SQRT: begin
        // rem_q holds the remaining radicand; restoring method on pairs of bits.
        rem_hi = rem_q >> (2 * cnt_q);
        sq_step = {root_q[23:0], 2'b01};
        if (rem_hi >= 50'(sq_step)) begin
          rem_d  = rem_q - (50'(sq_step) << (2 * cnt_q));
          root_d = {root_q[24:0], 1'b1};
        end else begin
          root_d = {root_q[24:0], 1'b0};
        end
        if (cnt_q == 5'd0) state_d = elsa_pkg::ST_MUL;
        else cnt_d = cnt_q - 1'b1;
      end
      elsa_pkg::ST_MUL:  state_d = elsa_pkg::ST_MUL2;
      elsa_pkg::ST_MUL2: state_d = elsa_pkg::ST_ADDR;
      elsa_pkg::ST_ADDR: state_d = elsa_pkg::ST_RD0;
      elsa_pkg::ST_RD0:  state_d = elsa_pkg::ST_WR0;
      elsa_pkg::ST_WR0:  state_d = elsa_pkg::ST_RD1;
      elsa_pkg::ST_RD1:  state_d = elsa_pkg::ST_WR1;
      elsa_pkg::ST_WR1:  state_d = elsa_pkg::ST_OUT;
      elsa_pkg::ST_RREAD: state_d = elsa_pkg::ST_RDATA;
      elsa_pkg::ST_RDATA: state_d = elsa_pkg::ST_OUT;
      elsa_pkg::ST_OUT: if (!ovalid_q || m_axis_tready) state_d = elsa_pkg::ST_IDLE;
      default: state_d = elsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= elsa_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Datapath registers.
  logic [47:0] v_mag;
  logic [73:0] m_sum;
  always_comb begin
    v_mag = 48'((prod_q[63] ? (64'd0 - prod_q) : prod_q) >> 16);
    m_sum = ((74'(root_q) * 74'(v_q[47:24])) << 11)
          + ((74'(root_q) * 74'(v_q[23:0])) >> 13);
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
    if (s_axis_tvalid && s_axis_tready) begin
      n0_q    <= s_axis_tdata[9:0];
      n1_q    <= s_axis_tdata[19:10];
      dx_q    <= 25'(signed'(s_axis_tdata[91:68])) - 25'(signed'(s_axis_tdata[43:20]));
      dy_q    <= 25'(signed'(s_axis_tdata[115:92])) - 25'(signed'(s_axis_tdata[67:44]));
      ev_q    <= s_axis_tdata[147:116];
      raddr_q <= s_axis_tdata[159:148];
      last_q  <= s_axis_tlast;
      contrib_q <= '0;
    end
    if (state_q == elsa_pkg::ST_SQ) prod_q <= 64'(scale_q * ev_q);
    if (state_q == elsa_pkg::ST_MUL) begin
      neg_q <= prod_q[63];
      v_q   <= v_mag;
    end
    if (state_q == elsa_pkg::ST_MUL2) m_q <= m_sum;
    if (state_q == elsa_pkg::ST_ADDR) begin
      if (neg_q) contrib_q <= (m_q > 74'(elsa_pkg::AccMax) + 74'd1) ? elsa_pkg::AccMin
                              : AccW'(74'd0 - m_q);
      else       contrib_q <= (m_q > 74'(elsa_pkg::AccMax)) ? elsa_pkg::AccMax : AccW'(m_q);
      a0_q   <= (AddrW+17)'(n0_q) * (AddrW+17)'(bsize_q) + (AddrW+17)'(comp_q);
      a1_q   <= (AddrW+17)'(n1_q) * (AddrW+17)'(bsize_q) + (AddrW+17)'(comp_q);
    end
  end
  assign a0_ok = a0_q < (AddrW+17)'(Depth);
  assign a1_ok = a1_q < (AddrW+17)'(Depth);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (state_q == elsa_pkg::ST_OUT && (!ovalid_q || m_axis_tready)) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  // Result fields; read data outside the store returns zero.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      err_pend_q <= (s_axis_tuser == elsa_pkg::CMD_ADD) && ({1'b0, comp_q} >= bsize_q);
    if (state_q == elsa_pkg::ST_RDATA)
      rd_hold_q <= (32'(raddr_q) < Depth) ? rdata_q : '0;
    if (state_q == elsa_pkg::ST_OUT && (!ovalid_q || m_axis_tready)) begin
      ocontrib_q <= contrib_q;
      ordata_q   <= rd_hold_q;
      oerr_q     <= err_pend_q;
      olast_q    <= last_q;
    end
    if (s_axis_tvalid && s_axis_tready) rd_hold_q <= '0;
  end

  // Checks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready) else $error("item taken during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == elsa_pkg::ST_WR0) |-> $past(state_q) == elsa_pkg::ST_RD0)
    else $error("write without read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");

endmodule
